// ----- rtl/core/erm_pkg.sv -----
// erm_pkg: constants, types and helpers for the euler rotation matrix core
// no dependencies
package erm_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int MAX_STAGES = 24;
	localparam int STAGES = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
	localparam int AW = 34;
	localparam int CW = 32;
	localparam int SCW = 22;
	localparam int PW = 44;
	localparam int SUMW = 45;

	localparam logic signed [AW-1:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [CW-1:0] X_INIT =
		CW'(64'd652032875 + (64'd434688583 >> (2 * STAGES)));
	localparam logic signed [SCW-1:0] ONE_Q20 = 22'sd1048576;

	typedef logic signed [CW-1:0] cw_t;
	typedef logic signed [AW-1:0] aw_t;
	typedef logic signed [SCW-1:0] sc_t;

	typedef struct packed {
		sc_t s;
		sc_t c;
	} sincos_t;

	function automatic aw_t atan_q30(input int i);
		unique case (i)
			0: atan_q30 = 34'sd843314856;
			1: atan_q30 = 34'sd497837829;
			2: atan_q30 = 34'sd263043836;
			3: atan_q30 = 34'sd133525158;
			4: atan_q30 = 34'sd67021686;
			5: atan_q30 = 34'sd33543515;
			6: atan_q30 = 34'sd16775850;
			7: atan_q30 = 34'sd8388437;
			8: atan_q30 = 34'sd4194282;
			9: atan_q30 = 34'sd2097149;
			10: atan_q30 = 34'sd1048575;
			11: atan_q30 = 34'sd524287;
			12: atan_q30 = 34'sd262143;
			13: atan_q30 = 34'sd131071;
			14: atan_q30 = 34'sd65535;
			15: atan_q30 = 34'sd32767;
			16: atan_q30 = 34'sd16383;
			17: atan_q30 = 34'sd8191;
			18: atan_q30 = 34'sd4095;
			19: atan_q30 = 34'sd2047;
			20: atan_q30 = 34'sd1023;
			21: atan_q30 = 34'sd511;
			22: atan_q30 = 34'sd255;
			default: atan_q30 = 34'sd127;
		endcase
	endfunction

	// round q.40 to q1.14, ties up, saturate to +-1
	function automatic logic signed [15:0] to_q14(input logic signed [SUMW-1:0] v);
		logic signed [SUMW-1:0] r;
		r = (v + SUMW'(64'sd1 <<< 25)) >>> 26;
		if (r > 45'sd16384) to_q14 = 16'sd16384;
		else if (r < -45'sd16384) to_q14 = -16'sd16384;
		else to_q14 = r[15:0];
	endfunction

endpackage

// ----- rtl/core/erm_cordic.sv -----
// erm_cordic: pipelined rotation-mode cordic, one stage per cycle, sine/cosine in q.20
// depends on erm_pkg
module erm_cordic import erm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic signed [15:0] angle,
	output logic out_valid,
	output sincos_t sc
);
	aw_t z_s [STAGES+1];
	cw_t x_s [STAGES+1];
	cw_t y_s [STAGES+1];
	logic neg_s [STAGES+1];
	logic v_s [STAGES+1];
	aw_t za;
	sincos_t sc_q;
	logic vo_q;

	always_comb begin
		za = aw_t'(angle) <<< 17;
	end

	// fold into [-pi/2, pi/2]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0] <= X_INIT;
		y_s[0] <= '0;
		if (za > HALF_PI_Q30) begin
			z_s[0] <= za - PI_Q30;
			neg_s[0] <= 1'b1;
		end else if (za < -HALF_PI_Q30) begin
			z_s[0] <= za + PI_Q30;
			neg_s[0] <= 1'b1;
		end else begin
			z_s[0] <= za;
			neg_s[0] <= 1'b0;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			neg_s[i+1] <= neg_s[i];
			if (!z_s[i][AW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_q30(i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_q30(i);
			end
		end
	end

	function automatic sc_t rnd_clamp(input cw_t v, input logic n);
		logic signed [CW-10:0] r;
		sc_t t;
		r = (CW-9)'(CW'(v + 32'sd512) >>> 10);
		if (r > 23'sd1048576) t = ONE_Q20;
		else if (r < -23'sd1048576) t = -ONE_Q20;
		else t = r[SCW-1:0];
		rnd_clamp = n ? -t : t;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else begin
			vo_q <= v_s[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		sc_q.c <= rnd_clamp(x_s[STAGES], neg_s[STAGES]);
		sc_q.s <= rnd_clamp(y_s[STAGES], neg_s[STAGES]);
	end

	assign out_valid = vo_q;
	assign sc = sc_q;
endmodule

// ----- rtl/core/erm_matrix.sv -----
// erm_matrix: three-stage product/sum pipeline forming the nine matrix entries
// depends on erm_pkg
module erm_matrix import erm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  sincos_t scx,
	input  sincos_t scy,
	input  sincos_t scz,
	output logic out_valid,
	output logic signed [15:0] e [9]
);
	logic signed [PW-1:0] czsy_p, szsy_p;
	sc_t czsy_s1, szsy_s1;
	sincos_t x_s1, y_s1, z_s1;
	logic signed [PW-1:0] p_s2 [12];
	logic signed [15:0] ny_s2;
	logic signed [15:0] e_s3 [9];
	logic v_s1, v_s2, v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		czsy_p = PW'(scz.c) * PW'(scy.s) + PW'(44'sd524288);
		szsy_p = PW'(scz.s) * PW'(scy.s) + PW'(44'sd524288);
	end

	// stage 1: shared double products rounded to q.20
	always_ff @(posedge clk) begin
		czsy_s1 <= SCW'(czsy_p >>> 20);
		szsy_s1 <= SCW'(szsy_p >>> 20);
		x_s1 <= scx;
		y_s1 <= scy;
		z_s1 <= scz;
	end

	// stage 2: products in q.40
	always_ff @(posedge clk) begin
		p_s2[0] <= PW'(z_s1.c) * PW'(y_s1.c);
		p_s2[1] <= PW'(czsy_s1) * PW'(x_s1.s);
		p_s2[2] <= PW'(z_s1.s) * PW'(x_s1.c);
		p_s2[3] <= PW'(czsy_s1) * PW'(x_s1.c);
		p_s2[4] <= PW'(z_s1.s) * PW'(x_s1.s);
		p_s2[5] <= PW'(z_s1.s) * PW'(y_s1.c);
		p_s2[6] <= PW'(szsy_s1) * PW'(x_s1.s);
		p_s2[7] <= PW'(z_s1.c) * PW'(x_s1.c);
		p_s2[8] <= PW'(szsy_s1) * PW'(x_s1.c);
		p_s2[9] <= PW'(z_s1.c) * PW'(x_s1.s);
		p_s2[10] <= PW'(y_s1.c) * PW'(x_s1.s);
		p_s2[11] <= PW'(y_s1.c) * PW'(x_s1.c);
	end

	always_ff @(posedge clk) begin
		ny_s2 <= to_q14(-(SUMW'(y_s1.s) <<< 20));
	end

	// stage 3: sums, rounding, saturation
	always_ff @(posedge clk) begin
		e_s3[0] <= to_q14(SUMW'(p_s2[0]));
		e_s3[1] <= to_q14(SUMW'(p_s2[1]) - SUMW'(p_s2[2]));
		e_s3[2] <= to_q14(SUMW'(p_s2[3]) + SUMW'(p_s2[4]));
		e_s3[3] <= to_q14(SUMW'(p_s2[5]));
		e_s3[4] <= to_q14(SUMW'(p_s2[6]) + SUMW'(p_s2[7]));
		e_s3[5] <= to_q14(SUMW'(p_s2[8]) - SUMW'(p_s2[9]));
		e_s3[6] <= ny_s2;
		e_s3[7] <= to_q14(SUMW'(p_s2[10]));
		e_s3[8] <= to_q14(SUMW'(p_s2[11]));
	end

	always_comb begin
		for (int k = 0; k < 9; k++) e[k] = e_s3[k];
	end
	assign out_valid = v_s3;
endmodule

// ----- rtl/core/euler_rotation_matrix_core.sv -----
// euler_rotation_matrix_core: z*y*x euler angles to rotation matrix, q3.13 in, q1.14 out
// depends on erm_pkg, erm_cordic, erm_matrix
// path: start passes through the cordic fold, iteration and output registers, then the matrix pipeline, to done
// throughput: one request per cycle; busy is held low, the receiver cannot stall
// reset: arst_n clears all valid bits asynchronously; data registers are not reset
module euler_rotation_matrix_core import erm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [15:0] angle_x,
	input  logic signed [15:0] angle_y,
	input  logic signed [15:0] angle_z,
	output logic done,
	output logic signed [15:0] v0_e0,
	output logic signed [15:0] v0_e1,
	output logic signed [15:0] v0_e2,
	output logic signed [15:0] v1_e0,
	output logic signed [15:0] v1_e1,
	output logic signed [15:0] v1_e2,
	output logic signed [15:0] v2_e0,
	output logic signed [15:0] v2_e1,
	output logic signed [15:0] v2_e2
);
	sincos_t scx, scy, scz;
	logic vx, vy, vz;
	logic signed [15:0] e [9];

	// every stage advances each cycle, so a new request is always taken
	assign busy = 1'b0;

	// three parallel cordic pipelines, one per angle
	erm_cordic u_cx (.clk, .arst_n, .in_valid(start), .angle(angle_x), .out_valid(vx), .sc(scx));
	erm_cordic u_cy (.clk, .arst_n, .in_valid(start), .angle(angle_y), .out_valid(vy), .sc(scy));
	erm_cordic u_cz (.clk, .arst_n, .in_valid(start), .angle(angle_z), .out_valid(vz), .sc(scz));

	// products, sums and rounding to q1.14
	erm_matrix u_mat (
		.clk, .arst_n,
		.in_valid(vx & vy & vz),
		.scx, .scy, .scz,
		.out_valid(done),
		.e
	);

	assign v0_e0 = e[0];
	assign v0_e1 = e[1];
	assign v0_e2 = e[2];
	assign v1_e0 = e[3];
	assign v1_e1 = e[4];
	assign v1_e2 = e[5];
	assign v2_e0 = e[6];
	assign v2_e1 = e[7];
	assign v2_e2 = e[8];
endmodule
